/* rtl/eprt_pkg.sv */
// ---------------------------------------------------------------------------
// eprt_pkg
// Types and constants shared by the endpoint pair relay table and its cells.
// ---------------------------------------------------------------------------
package eprt_pkg;

  // action codes
  localparam logic [1:0] ACT_ADD      = 2'd0;
  localparam logic [1:0] ACT_DEL_POS  = 2'd1;
  localparam logic [1:0] ACT_DEL_PAIR = 2'd2;
  localparam logic [1:0] ACT_LOOKUP   = 2'd3;

  // status codes
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_RANGE    = 3'd1;
  localparam logic [2:0] STAT_EXISTS   = 3'd2;
  localparam logic [2:0] STAT_FULL     = 3'd3;
  localparam logic [2:0] STAT_NOTFOUND = 3'd4;

  // legal port window for a new pair
  localparam logic [15:0] PORT_MIN = 16'd1024;
  localparam logic [15:0] PORT_MAX = 16'd65534;

  // width of the reported entry count
  localparam int unsigned CNT_OUT_W = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RES
  } state_t;

  // input beat
  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] first_ip;
    logic [15:0] first_port;
    logic [31:0] second_ip;
    logic [15:0] second_port;
    logic [4:0]  position;
    logic [31:0] src_ip;
    logic [15:0] src_port;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [2:0]  status;
    logic        conflict_second;
    logic        dest_valid;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
    logic [4:0]  entry_count;
  } out_item_t;

  // one stored pair
  typedef struct packed {
    logic [31:0] a_ip;
    logic [15:0] a_port;
    logic [31:0] b_ip;
    logic [15:0] b_port;
  } entry_t;

  // hit seen in any earlier cell, rippled down the row
  typedef struct packed {
    logic add;
    logic del;
    logic lk;
  } seen_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic cmp_en;
    logic valid;
    logic shift_en;
    logic wr_en;
  } cell_ctrl_t;

  // per-cell contribution to the result
  typedef struct packed {
    logic        add_first;
    logic        csec;
    logic        del_tail;
    logic        lk_first;
    logic [31:0] dest_ip;
    logic [15:0] dest_port;
  } cell_res_t;

endpackage

/* rtl/eprt_cell.sv */
// ---------------------------------------------------------------------------
// eprt_cell
// One table slot: holds a pair, compares it against the current command,
// takes part in the first-hit ripple and shifts up from its neighbor on delete.
// ---------------------------------------------------------------------------
module eprt_cell (
  input  logic                 clk,
  input  eprt_pkg::in_item_t   cmd,
  input  eprt_pkg::cell_ctrl_t ctrl,
  input  eprt_pkg::entry_t     nbr,
  input  eprt_pkg::seen_t      seen_in,
  output eprt_pkg::seen_t      seen_out,
  output eprt_pkg::entry_t     entry,
  output eprt_pkg::cell_res_t  res
);
  import eprt_pkg::*;

  entry_t entry_r;
  logic   add_f_r, add_s_r, del_r, lk_a_r, lk_b_r;
  logic   f_a, f_b, s_a, s_b, lk_a, lk_b, exact;

  // endpoint compares against the command
  always_comb begin
    f_a   = (entry_r.a_ip == cmd.first_ip) && (entry_r.a_port == cmd.first_port);
    f_b   = (entry_r.b_ip == cmd.first_ip) && (entry_r.b_port == cmd.first_port);
    s_a   = (entry_r.a_ip == cmd.second_ip) && (entry_r.a_port == cmd.second_port);
    s_b   = (entry_r.b_ip == cmd.second_ip) && (entry_r.b_port == cmd.second_port);
    exact = f_a && (entry_r.b_ip == cmd.second_ip) &&
            (entry_r.b_port == cmd.second_port);
    lk_a  = (entry_r.a_port == cmd.src_port) &&
            ((entry_r.a_ip == '0) || (entry_r.a_ip == cmd.src_ip));
    lk_b  = (entry_r.b_port == cmd.src_port) &&
            ((entry_r.b_ip == '0) || (entry_r.b_ip == cmd.src_ip));
  end

  // hit flags, only for occupied slots
  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      add_f_r <= ctrl.valid && (f_a || f_b);
      add_s_r <= ctrl.valid && (s_a || s_b);
      del_r   <= ctrl.valid && exact;
      lk_a_r  <= ctrl.valid && lk_a;
      lk_b_r  <= ctrl.valid && lk_b;
    end
  end

  // first-hit ripple and result contribution
  always_comb begin
    seen_out.add  = seen_in.add || add_f_r || add_s_r;
    seen_out.del  = seen_in.del || del_r;
    seen_out.lk   = seen_in.lk || lk_a_r || lk_b_r;
    res.add_first = (add_f_r || add_s_r) && !seen_in.add;
    res.csec      = res.add_first && !add_f_r;
    res.del_tail  = seen_out.del;
    res.lk_first  = (lk_a_r || lk_b_r) && !seen_in.lk;
    res.dest_ip   = '0;
    res.dest_port = '0;
    if (res.lk_first) begin
      if (lk_a_r) begin
        res.dest_ip   = entry_r.b_ip;
        res.dest_port = entry_r.b_port;
      end else begin
        res.dest_ip   = entry_r.a_ip;
        res.dest_port = entry_r.a_port;
      end
    end
  end

  // slot update: append or move up from the next slot
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      entry_r.a_ip   <= cmd.first_ip;
      entry_r.a_port <= cmd.first_port;
      entry_r.b_ip   <= cmd.second_ip;
      entry_r.b_port <= cmd.second_port;
    end else if (ctrl.shift_en) begin
      entry_r <= nbr;
    end
  end

  assign entry = entry_r;

endmodule

/* rtl/endpoint_pair_relay_table_unit.sv */
// ---------------------------------------------------------------------------
// endpoint_pair_relay_table_unit
// Ordered relay table of endpoint pairs with add, delete and forward lookup.
// ---------------------------------------------------------------------------
// Each command is taken when start is high and busy is low. Busy rises for
// exactly one cycle after a command is taken, and a new command can be taken
// again once busy falls. The result shows on out_data for one cycle with
// out_valid high, from the output register after the result step; there is no
// back-pressure, so the receiver must capture it then. The steps come from
// the row of slots: a compare step in which every slot compares itself against
// the command, then a result step in which the first hit ripples down the row,
// the result is formed and the slots append or move up.
module endpoint_pair_relay_table_unit #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  eprt_pkg::in_item_t  in_data,
  output logic                out_valid,
  output eprt_pkg::out_item_t out_data
);
  import eprt_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

  state_t     state_r, state_nxt;
  in_item_t   cmd_r;
  logic [CW-1:0] count_r, count_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  entry_t     entries [TABLE_DEPTH];
  cell_ctrl_t ctrl    [TABLE_DEPTH];
  cell_res_t  res     [TABLE_DEPTH];
  seen_t      seen    [TABLE_DEPTH+1];

  logic accept;
  logic in_res;
  logic do_add, do_del_pos, do_del_pair;
  logic ports_ok, pos_ok, full;
  logic csec_any, lk_found;
  logic [31:0] dip_any;
  logic [15:0] dport_any;
  logic [PW-1:0] pos_w, cnt_w, cnt_out_w;

  assign accept = start && !busy;
  assign busy   = (state_r == ST_CMP);
  assign in_res = (state_r == ST_RES);

  // command register
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // row of slots
  assign seen[0] = '0;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    entry_t nbr;
    if (k == TABLE_DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = entries[k+1];
    end

    always_comb begin
      ctrl[k].cmp_en   = (state_r == ST_CMP);
      ctrl[k].valid    = (CW'(k) < count_r);
      ctrl[k].wr_en    = do_add && (count_r == CW'(k));
      ctrl[k].shift_en = (do_del_pos && (PW'(k + 1) >= pos_w)) ||
                         (do_del_pair && res[k].del_tail);
    end

    eprt_cell u_cell (
      .clk      (clk),
      .cmd      (cmd_r),
      .ctrl     (ctrl[k]),
      .nbr      (nbr),
      .seen_in  (seen[k]),
      .seen_out (seen[k+1]),
      .entry    (entries[k]),
      .res      (res[k])
    );
  end

  // gather the single first-hit contribution
  always_comb begin
    csec_any  = 1'b0;
    dip_any   = '0;
    dport_any = '0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      csec_any  = csec_any | res[k].csec;
      dip_any   = dip_any | res[k].dest_ip;
      dport_any = dport_any | res[k].dest_port;
    end
  end

  // decision checks
  always_comb begin
    pos_w    = PW'(cmd_r.position);
    cnt_w    = PW'(count_r);
    ports_ok = (cmd_r.first_port >= PORT_MIN) && (cmd_r.first_port <= PORT_MAX) &&
               (cmd_r.second_port >= PORT_MIN) && (cmd_r.second_port <= PORT_MAX);
    pos_ok   = (pos_w != '0) && (pos_w <= cnt_w);
    full     = (count_r == CW'(TABLE_DEPTH));
    lk_found = seen[TABLE_DEPTH].lk;
    do_add      = in_res && (cmd_r.action == ACT_ADD) && ports_ok &&
                  !seen[TABLE_DEPTH].add && !full;
    do_del_pos  = in_res && (cmd_r.action == ACT_DEL_POS) && pos_ok;
    do_del_pair = in_res && (cmd_r.action == ACT_DEL_PAIR) && seen[TABLE_DEPTH].del;
  end

  // next state, count and result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    cnt_out_w     = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_RES;
      end
      ST_RES: begin
        state_nxt = start ? ST_CMP : ST_IDLE;
        if (do_add) begin
          count_nxt = count_r + CW'(1);
        end else if (do_del_pos || do_del_pair) begin
          count_nxt = count_r - CW'(1);
        end

        out_data_nxt.status          = STAT_OK;
        out_data_nxt.conflict_second = 1'b0;
        out_data_nxt.dest_valid      = 1'b0;
        out_data_nxt.dest_ip         = '0;
        out_data_nxt.dest_port       = '0;
        case (cmd_r.action)
          ACT_ADD: begin
            if (!ports_ok) begin
              out_data_nxt.status = STAT_RANGE;
            end else if (seen[TABLE_DEPTH].add) begin
              out_data_nxt.status          = STAT_EXISTS;
              out_data_nxt.conflict_second = csec_any;
            end else if (full) begin
              out_data_nxt.status = STAT_FULL;
            end
          end
          ACT_DEL_POS: begin
            if (!pos_ok) begin
              out_data_nxt.status = STAT_NOTFOUND;
            end
          end
          ACT_DEL_PAIR: begin
            if (!seen[TABLE_DEPTH].del) begin
              out_data_nxt.status = STAT_NOTFOUND;
            end
          end
          default: begin
            if (lk_found) begin
              out_data_nxt.dest_valid = 1'b1;
              out_data_nxt.dest_ip    = dip_any;
              out_data_nxt.dest_port  = dport_any;
            end else begin
              out_data_nxt.status = STAT_NOTFOUND;
            end
          end
        endcase
        cnt_out_w                = PW'(count_nxt);
        out_data_nxt.entry_count = cnt_out_w[CNT_OUT_W-1:0];
        out_valid_nxt            = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/eprt_chk.sv */
// ---------------------------------------------------------------------------
// eprt_chk
// Port-level timing checks for the relay table, bound to the top level.
// ---------------------------------------------------------------------------
module eprt_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input eprt_pkg::out_item_t out_data
);
  import eprt_pkg::*;

  // a taken command makes the block busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not follow a taken command");

  // busy lasts one cycle
  a_busy_short: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held for more than one cycle");

  // every command yields its result after the result step that follows busy
  a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> ##1 out_valid)
    else $error("result missing after command");

  // results never come back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes in consecutive cycles");

  // a forward destination only comes with an ok status
  a_dest_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.dest_valid) |-> (out_data.status == STAT_OK))
    else $error("destination flagged with a failing status");

endmodule

bind endpoint_pair_relay_table_unit eprt_chk u_eprt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
